// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands for the design files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== design/mcmas_pkg.sv =====
// ----------------------------------------------------------------------------
// mcmas_pkg
// Shared types and constants of the matrix cell multiply/add/subtract engine.
// ----------------------------------------------------------------------------
package mcmas_pkg;

   localparam int ACTION_W = 3;
   localparam int INDEX_W  = 5;
   localparam int ENTRY_W  = 16;
   localparam int TERM_W   = 32;
   localparam int VALUE_W  = 40;
   localparam int CFG_W    = 5;
   localparam int CSR_IDX_W = 1;

   localparam logic [CFG_W-1:0] ROW_COUNT_RESET    = 5'd16;
   localparam logic [CFG_W-1:0] COLUMN_COUNT_RESET = 5'd16;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_COUNT = 1'd1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_WRITE_A = 3'd0,
      ACT_WRITE_B = 3'd1,
      ACT_PRODUCT = 3'd2,
      ACT_SUM     = 3'd3,
      ACT_DIFF    = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

endpackage

// ===== design/mcmas_if.sv =====
// ----------------------------------------------------------------------------
// mcmas_req_if / mcmas_rsp_if
// Valid/ready channels for request and response transactions.
// ----------------------------------------------------------------------------
interface mcmas_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [mcmas_pkg::ACTION_W-1:0]         action;
   logic [mcmas_pkg::INDEX_W-1:0]          row;
   logic [mcmas_pkg::INDEX_W-1:0]          col;
   logic signed [mcmas_pkg::ENTRY_W-1:0]   entry_value;

   modport source (output valid, action, row, col, entry_value, input ready);
   modport sink   (input valid, action, row, col, entry_value, output ready);
endinterface

interface mcmas_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [mcmas_pkg::INDEX_W-1:0]          out_row;
   logic [mcmas_pkg::INDEX_W-1:0]          out_col;
   logic signed [mcmas_pkg::VALUE_W-1:0]   cell_value;
   logic                                   nonzero;

   modport source (output valid, out_row, out_col, cell_value, nonzero, input ready);
   modport sink   (input valid, out_row, out_col, cell_value, nonzero, output ready);
endinterface

// ===== design/mcmas_mem.sv =====
// ----------------------------------------------------------------------------
// mcmas_mem
// Matrix entry store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mcmas_mem #(
   parameter int ADDR_W = 8
) (
   input  logic                                 clock,
   input  logic                                 we,
   input  logic [ADDR_W-1:0]                    waddr,
   input  logic signed [mcmas_pkg::ENTRY_W-1:0] wdata,
   input  logic [ADDR_W-1:0]                    raddr,
   output logic signed [mcmas_pkg::ENTRY_W-1:0] rdata
);

   localparam int DEPTH = 1 << ADDR_W;

   logic signed [mcmas_pkg::ENTRY_W-1:0] mem [DEPTH];
   logic signed [mcmas_pkg::ENTRY_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/matrix_cell_mul_add_sub.sv =====
// ----------------------------------------------------------------------------
// matrix_cell_mul_add_sub
// Integer matrix cell engine: stores matrices A and B and computes one cell
// of A*B, A+B or A-B per request transaction.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries write and compute transactions. A write of A or B gives
//   no response. A compute transaction (product, sum, difference) gives one
//   response on rsp_if; out-of-range cells and unused actions are dropped
//   without a response.
//   One shared multiply/add unit works through the cell: a product issues
//   one A/B read pair per row in use (row_count, capped at MAX_DIM), a sum
//   or difference a single pair. Each pair passes the registered read of
//   the two entry stores, the term register and the accumulator; the result
//   is loaded into the response register once the last term is
//   accumulated. req_if.ready stays low while a compute runs.
//   The response sits in an output register; the next transaction is taken
//   while it waits. A stalled receiver holds a finished compute until the
//   register frees.
//   csr_we/csr_index/csr_wdata write row_count and column_count (reset 16);
//   write only while idle.
//   Reset (synchronous) starts a clearing pass that zeroes all 2^(2*max(1,
//   ceil(log2 MAX_DIM))) entries of each store (256 at MAX_DIM = 16), during
//   which no request is accepted; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module matrix_cell_mul_add_sub #(
   parameter int MAX_DIM = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [mcmas_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mcmas_pkg::CFG_W-1:0]          csr_wdata,
   mcmas_req_if.sink                            req_if,
   mcmas_rsp_if.source                          rsp_if
);

   localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int CNT_W  = $clog2(MAX_DIM + 1);
   localparam int CW     = (CNT_W > mcmas_pkg::CFG_W) ? CNT_W : mcmas_pkg::CFG_W;
   localparam int ADDR_W = 2 * IDX_W;

   localparam logic [CW-1:0] MAX_C = CW'(MAX_DIM);

   // configuration
   logic [mcmas_pkg::CFG_W-1:0] row_count_ff, row_count_in;
   logic [mcmas_pkg::CFG_W-1:0] column_count_ff, column_count_in;

   // sequencer
   mcmas_pkg::state_type  state_ff, state_in;
   logic [ADDR_W-1:0]     clr_ff, clr_in;
   mcmas_pkg::action_type op_ff, op_in;
   logic [mcmas_pkg::INDEX_W-1:0] row_ff, row_in, col_ff, col_in;
   logic [IDX_W-1:0]      row_idx_ff, row_idx_in, col_idx_ff, col_idx_in;
   logic [IDX_W-1:0]      k_ff, k_in;
   logic                  issue_ff, issue_in;

   // datapath pipeline
   logic                  v1_ff, l1_ff, m1_ff;
   logic                  v2_ff, l2_ff;
   logic signed [mcmas_pkg::TERM_W-1:0]  term_ff, term_in;
   logic signed [mcmas_pkg::VALUE_W-1:0] acc_ff, acc_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [mcmas_pkg::INDEX_W-1:0] rsp_row_ff, rsp_col_ff;
   logic signed [mcmas_pkg::VALUE_W-1:0] rsp_value_ff;
   logic                  rsp_nonzero_ff;

   // decode
   logic [CW-1:0]         eff_row, eff_col, req_row_ext, req_col_ext;
   logic [CW-1:0]         req_row_m1, req_col_m1;
   logic [IDX_W-1:0]      req_row_idx, req_col_idx;
   logic                  req_accept, write_ok, compute_ok, is_write_a, is_write_b;
   logic                  is_compute, start, last_issue, mask_k, load;

   // memory ports
   logic                  we_a, we_b;
   logic [ADDR_W-1:0]     waddr, raddr_a, raddr_b;
   logic signed [mcmas_pkg::ENTRY_W-1:0] wdata, rdata_a, rdata_b, op_a, op_b;

   mcmas_mem #(.ADDR_W(ADDR_W)) u_mem_a (
      .clock (clock),
      .we    (we_a),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr_a),
      .rdata (rdata_a)
   );

   mcmas_mem #(.ADDR_W(ADDR_W)) u_mem_b (
      .clock (clock),
      .we    (we_b),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr_b),
      .rdata (rdata_b)
   );

   always_comb begin
      eff_row = (CW'(row_count_ff) > MAX_C) ? MAX_C : CW'(row_count_ff);
      eff_col = (CW'(column_count_ff) > MAX_C) ? MAX_C : CW'(column_count_ff);
      req_row_ext = CW'(req_if.row);
      req_col_ext = CW'(req_if.col);
      req_row_m1  = req_row_ext - CW'(1);
      req_col_m1  = req_col_ext - CW'(1);
      req_row_idx = req_row_m1[IDX_W-1:0];
      req_col_idx = req_col_m1[IDX_W-1:0];
      write_ok   = (req_if.row != '0) && (req_if.col != '0) &&
                   (req_row_ext <= MAX_C) && (req_col_ext <= MAX_C);
      compute_ok = (req_if.row != '0) && (req_if.col != '0) &&
                   (req_row_ext <= eff_row) && (req_col_ext <= eff_col);
      is_write_a = 1'b0;
      is_write_b = 1'b0;
      is_compute = 1'b0;
      unique case (req_if.action) inside
         mcmas_pkg::ACT_WRITE_A: is_write_a = 1'b1;
         mcmas_pkg::ACT_WRITE_B: is_write_b = 1'b1;
         mcmas_pkg::ACT_PRODUCT, mcmas_pkg::ACT_SUM, mcmas_pkg::ACT_DIFF:
            is_compute = 1'b1;
         default: ;
      endcase
   end

   assign last_issue = (op_ff != mcmas_pkg::ACT_PRODUCT) ||
                       (CW'(k_ff) == (eff_row - CW'(1)));
   assign mask_k     = (op_ff != mcmas_pkg::ACT_PRODUCT) || (CW'(k_ff) < eff_col);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mcmas_pkg::ST_CLEAR: begin
            if (clr_ff == '1) begin
               state_in = mcmas_pkg::ST_IDLE;
            end
         end
         mcmas_pkg::ST_IDLE: begin
            if (start) begin
               state_in = mcmas_pkg::ST_RUN;
            end
         end
         mcmas_pkg::ST_RUN: begin
            if (v2_ff && l2_ff) begin
               state_in = mcmas_pkg::ST_FINISH;
            end
         end
         mcmas_pkg::ST_FINISH: begin
            if (load) begin
               state_in = mcmas_pkg::ST_IDLE;
            end
         end
         default: state_in = mcmas_pkg::ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      req_if.ready = 1'b0;
      load         = 1'b0;
      we_a         = 1'b0;
      we_b         = 1'b0;
      waddr        = {req_row_idx, req_col_idx};
      wdata        = req_if.entry_value;
      unique case (state_ff)
         mcmas_pkg::ST_CLEAR: begin
            we_a  = 1'b1;
            we_b  = 1'b1;
            waddr = clr_ff;
            wdata = '0;
         end
         mcmas_pkg::ST_IDLE: begin
            req_if.ready = 1'b1;
            we_a = req_if.valid && is_write_a && write_ok;
            we_b = req_if.valid && is_write_b && write_ok;
         end
         mcmas_pkg::ST_RUN: ;
         mcmas_pkg::ST_FINISH: begin
            load = !rsp_valid_ff || rsp_if.ready;
         end
         default: ;
      endcase
   end

   assign req_accept = req_if.valid && req_if.ready;
   assign start      = req_accept && is_compute && compute_ok;

   always_comb begin
      if (op_ff == mcmas_pkg::ACT_PRODUCT) begin
         raddr_a = {row_idx_ff, k_ff};
         raddr_b = {k_ff, col_idx_ff};
      end else begin
         raddr_a = {row_idx_ff, col_idx_ff};
         raddr_b = {row_idx_ff, col_idx_ff};
      end
   end

   // sequencer and shared arithmetic unit
   always_comb begin
      row_count_in    = row_count_ff;
      column_count_in = column_count_ff;
      if (csr_we) begin
         unique case (csr_index)
            mcmas_pkg::CSR_ROW_COUNT:    row_count_in    = csr_wdata;
            mcmas_pkg::CSR_COLUMN_COUNT: column_count_in = csr_wdata;
            default: ;
         endcase
      end

      clr_in     = (state_ff == mcmas_pkg::ST_CLEAR) ? clr_ff + ADDR_W'(1) : clr_ff;
      op_in      = op_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      row_idx_in = row_idx_ff;
      col_idx_in = col_idx_ff;
      k_in       = k_ff;
      issue_in   = issue_ff;
      acc_in     = acc_ff;

      if (start) begin
         op_in      = mcmas_pkg::action_type'(req_if.action);
         row_in     = req_if.row;
         col_in     = req_if.col;
         row_idx_in = req_row_idx;
         col_idx_in = req_col_idx;
         k_in       = '0;
         issue_in   = 1'b1;
         acc_in     = '0;
      end else begin
         if (issue_ff) begin
            k_in = k_ff + IDX_W'(1);
            if (last_issue) begin
               issue_in = 1'b0;
            end
         end
         if (v2_ff) begin
            acc_in = acc_ff + mcmas_pkg::VALUE_W'(term_ff);
         end
      end

      op_a = m1_ff ? rdata_a : '0;
      op_b = rdata_b;
      case (op_ff)
         mcmas_pkg::ACT_PRODUCT:
            term_in = mcmas_pkg::TERM_W'(op_a) * mcmas_pkg::TERM_W'(op_b);
         mcmas_pkg::ACT_SUM:
            term_in = mcmas_pkg::TERM_W'(op_a) + mcmas_pkg::TERM_W'(op_b);
         default:
            term_in = mcmas_pkg::TERM_W'(op_a) - mcmas_pkg::TERM_W'(op_b);
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= mcmas_pkg::ST_CLEAR;
         clr_ff          <= '0;
         row_count_ff    <= mcmas_pkg::ROW_COUNT_RESET;
         column_count_ff <= mcmas_pkg::COLUMN_COUNT_RESET;
         issue_ff        <= 1'b0;
         v1_ff           <= 1'b0;
         v2_ff           <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clr_ff          <= clr_in;
         row_count_ff    <= row_count_in;
         column_count_ff <= column_count_in;
         issue_ff        <= issue_in;
         v1_ff           <= issue_ff && !start;
         v2_ff           <= v1_ff;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      row_ff     <= row_in;
      col_ff     <= col_in;
      row_idx_ff <= row_idx_in;
      col_idx_ff <= col_idx_in;
      k_ff       <= k_in;
      acc_ff     <= acc_in;
      l1_ff      <= last_issue;
      m1_ff      <= mask_k;
      l2_ff      <= l1_ff;
      term_ff    <= term_in;
      if (load) begin
         rsp_row_ff     <= row_ff;
         rsp_col_ff     <= col_ff;
         rsp_value_ff   <= acc_ff;
         rsp_nonzero_ff <= (acc_ff != '0);
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.out_row    = rsp_row_ff;
   assign rsp_if.out_col    = rsp_col_ff;
   assign rsp_if.cell_value = rsp_value_ff;
   assign rsp_if.nonzero    = rsp_nonzero_ff;

   `ASSERT_IMPLIES(a_pipe_in_run, clock, reset, v2_ff, state_ff == mcmas_pkg::ST_RUN, "accumulate outside run")
   `ASSERT_IMPLIES(a_clear_no_rsp, clock, reset, state_ff == mcmas_pkg::ST_CLEAR, !rsp_valid_ff, "response during clear")
   `ASSERT_NEXT(a_load_sets_valid, clock, reset, load, rsp_valid_ff && state_ff == mcmas_pkg::ST_IDLE, "finished compute not posted")
   `ASSERT_IMPLIES(a_no_issue_idle, clock, reset, state_ff == mcmas_pkg::ST_IDLE, !issue_ff && !v1_ff && !v2_ff, "pipeline busy while idle")

endmodule

// ===== sim/matrix_cell_mul_add_sub_tb.sv =====
// ----------------------------------------------------------------------------
// matrix_cell_mul_add_sub_tb
// Self-checking bench for the matrix cell engine. Directed writes and
// computes cover the entry extremes, every action, dropped writes and
// computes, and unused actions. Random traffic then runs under several row
// and column count settings, with random request gaps and response stalls. A
// scoreboard keeps its own copy of both matrices and checks each response
// in order.
// ----------------------------------------------------------------------------
module matrix_cell_mul_add_sub_tb;

   localparam int DIM           = 16;
   localparam int LIMIT_CYCLES  = 1000000;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 300;

   localparam logic signed [mcmas_pkg::ENTRY_W-1:0] ENTRY_MAX =
      {1'b0, {(mcmas_pkg::ENTRY_W-1){1'b1}}};
   localparam logic signed [mcmas_pkg::ENTRY_W-1:0] ENTRY_MIN =
      {1'b1, {(mcmas_pkg::ENTRY_W-1){1'b0}}};
   localparam logic [mcmas_pkg::ACTION_W-1:0] ACT_SPARE_FIRST =
      mcmas_pkg::ACTION_W'(int'(mcmas_pkg::ACT_DIFF) + 1);
   localparam logic [mcmas_pkg::ACTION_W-1:0] ACT_SPARE_LAST  = '1;

   typedef struct {
      logic [mcmas_pkg::INDEX_W-1:0]        row;
      logic [mcmas_pkg::INDEX_W-1:0]        col;
      logic signed [mcmas_pkg::VALUE_W-1:0] value;
      logic                                 nonzero;
   } cell_result_type;

   class cell_scoreboard;
      logic signed [mcmas_pkg::ENTRY_W-1:0] a_store [DIM][DIM];
      logic signed [mcmas_pkg::ENTRY_W-1:0] b_store [DIM][DIM];
      logic [mcmas_pkg::CFG_W-1:0] rows_used;
      logic [mcmas_pkg::CFG_W-1:0] cols_used;
      cell_result_type  pending [$];
      int               errors;

      function new();
         foreach (a_store[i, j]) begin
            a_store[i][j] = '0;
            b_store[i][j] = '0;
         end
         rows_used = mcmas_pkg::ROW_COUNT_RESET;
         cols_used = mcmas_pkg::COLUMN_COUNT_RESET;
         errors = 0;
      endfunction

      function int span(logic [mcmas_pkg::CFG_W-1:0] n);
         return (n > DIM) ? DIM : int'(n);
      endfunction

      function void set_count(logic [mcmas_pkg::CSR_IDX_W-1:0] idx,
                              logic [mcmas_pkg::CFG_W-1:0] n);
         if (idx == mcmas_pkg::CSR_ROW_COUNT)
            rows_used = n;
         else if (idx == mcmas_pkg::CSR_COLUMN_COUNT)
            cols_used = n;
      endfunction

      function longint entry(bit from_b, int r, int c);
         if (r < 1 || c < 1 || r > span(rows_used) || c > span(cols_used))
            return 0;
         if (from_b)
            return longint'(b_store[r-1][c-1]);
         return longint'(a_store[r-1][c-1]);
      endfunction

      function void note_request(logic [mcmas_pkg::ACTION_W-1:0] act,
                                 logic [mcmas_pkg::INDEX_W-1:0] row,
                                 logic [mcmas_pkg::INDEX_W-1:0] col,
                                 logic signed [mcmas_pkg::ENTRY_W-1:0] val);
         longint          acc;
         cell_result_type res;
         int              r;
         int              c;
         int              k;
         r = int'(row);
         c = int'(col);
         acc = 0;
         if (act == mcmas_pkg::ACT_WRITE_A || act == mcmas_pkg::ACT_WRITE_B) begin
            if (r >= 1 && c >= 1 && r <= DIM && c <= DIM) begin
               if (act == mcmas_pkg::ACT_WRITE_A)
                  a_store[r-1][c-1] = val;
               else
                  b_store[r-1][c-1] = val;
            end
            return;
         end
         if (act > mcmas_pkg::ACT_DIFF)
            return;
         if (r < 1 || c < 1 || r > span(rows_used) || c > span(cols_used))
            return;
         case (act)
            mcmas_pkg::ACT_PRODUCT: begin
               for (k = 1; k <= span(rows_used); k++)
                  acc += entry(0, r, k) * entry(1, k, c);
            end
            mcmas_pkg::ACT_SUM:  acc = entry(0, r, c) + entry(1, r, c);
            default:             acc = entry(0, r, c) - entry(1, r, c);
         endcase
         res.row = row;
         res.col = col;
         res.value = acc[mcmas_pkg::VALUE_W-1:0];
         res.nonzero = (acc[mcmas_pkg::VALUE_W-1:0] != 0);
         pending.push_back(res);
      endfunction

      function void check_result(logic [mcmas_pkg::INDEX_W-1:0] row,
                                 logic [mcmas_pkg::INDEX_W-1:0] col,
                                 logic signed [mcmas_pkg::VALUE_W-1:0] value,
                                 logic nonzero);
         cell_result_type want;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t unexpected response: expected none, got row %0d col %0d value %0d",
                     $time, row, col, value);
            return;
         end
         want = pending.pop_front();
         if (row !== want.row) begin
            errors++;
            $display("%0t out_row mismatch: expected %0d, got %0d", $time, want.row, row);
         end
         if (col !== want.col) begin
            errors++;
            $display("%0t out_col mismatch: expected %0d, got %0d", $time, want.col, col);
         end
         if (value !== want.value) begin
            errors++;
            $display("%0t cell_value mismatch (cell %0d,%0d): expected %0d, got %0d",
                     $time, want.row, want.col, want.value, value);
         end
         if (nonzero !== want.nonzero) begin
            errors++;
            $display("%0t nonzero mismatch (cell %0d,%0d): expected %0b, got %0b",
                     $time, want.row, want.col, want.nonzero, nonzero);
         end
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_we;
   logic [mcmas_pkg::CSR_IDX_W-1:0] csr_index;
   logic [mcmas_pkg::CFG_W-1:0]     csr_wdata;
   bit                              hold_request;
   int                              cycle_count = 0;
   int                              calm_left = 0;

   cell_scoreboard cells = new();

   mcmas_req_if req_ch ();
   mcmas_rsp_if rsp_ch ();

   matrix_cell_mul_add_sub #(.MAX_DIM(DIM)) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_if    (req_ch.sink),
      .rsp_if    (rsp_ch.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         cells.check_result(rsp_ch.out_row, rsp_ch.out_col, rsp_ch.cell_value,
                            rsp_ch.nonzero);
   end

   initial begin : responder
      int stall_left;
      int run_left;
      int r;
      rsp_ch.ready = 1'b0;
      stall_left = 0;
      run_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left = HOLD_CYCLES;
            run_left = 0;
         end
         if (stall_left > 0) begin
            rsp_ch.ready = 1'b0;
            stall_left--;
         end else if (run_left > 0) begin
            rsp_ch.ready = 1'b1;
            run_left--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
               run_left = $urandom_range(20, 80);
               rsp_ch.ready = 1'b1;
            end else if (r < 60) begin
               rsp_ch.ready = 1'b1;
            end else if (r < 95) begin
               stall_left = $urandom_range(0, 2);
               rsp_ch.ready = 1'b0;
            end else begin
               stall_left = $urandom_range(10, 40);
               rsp_ch.ready = 1'b0;
            end
         end
      end
   end

   function automatic int next_gap();
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [mcmas_pkg::ENTRY_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return ENTRY_MAX;
         1:       return ENTRY_MIN;
         2:       return '0;
         default: return mcmas_pkg::ENTRY_W'($urandom);
      endcase
   endfunction

   // Leaves valid high after the transaction when gap is zero; the caller
   // sends again or lowers valid in the same step.
   task automatic send_request(input logic [mcmas_pkg::ACTION_W-1:0] act,
                               input logic [mcmas_pkg::INDEX_W-1:0] row,
                               input logic [mcmas_pkg::INDEX_W-1:0] col,
                               input logic signed [mcmas_pkg::ENTRY_W-1:0] val,
                               input int gap);
      req_ch.action = act;
      req_ch.row = row;
      req_ch.col = col;
      req_ch.entry_value = val;
      req_ch.valid = 1'b1;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      cells.note_request(act, row, col, val);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_random(input bit compute_only);
      logic [mcmas_pkg::ACTION_W-1:0] act;
      logic [mcmas_pkg::INDEX_W-1:0]  r;
      logic [mcmas_pkg::INDEX_W-1:0]  c;
      int                             pick;
      int                             hi_r;
      int                             hi_c;
      pick = compute_only ? $urandom_range(60, 94) : $urandom_range(0, 99);
      if (pick < 30)
         act = mcmas_pkg::ACT_WRITE_A;
      else if (pick < 60)
         act = mcmas_pkg::ACT_WRITE_B;
      else if (pick < 72)
         act = mcmas_pkg::ACT_PRODUCT;
      else if (pick < 84)
         act = mcmas_pkg::ACT_SUM;
      else if (pick < 95)
         act = mcmas_pkg::ACT_DIFF;
      else
         act = mcmas_pkg::ACTION_W'($urandom_range(int'(ACT_SPARE_FIRST),
                                                   int'(ACT_SPARE_LAST)));
      if (act == mcmas_pkg::ACT_WRITE_A || act == mcmas_pkg::ACT_WRITE_B) begin
         hi_r = DIM;
         hi_c = DIM;
      end else begin
         hi_r = cells.span(cells.rows_used);
         hi_c = cells.span(cells.cols_used);
         if (hi_r == 0)
            hi_r = DIM;
         if (hi_c == 0)
            hi_c = DIM;
      end
      if ($urandom_range(0, 9) == 0) begin
         r = mcmas_pkg::INDEX_W'($urandom);
         c = mcmas_pkg::INDEX_W'($urandom);
      end else begin
         r = mcmas_pkg::INDEX_W'($urandom_range(1, hi_r));
         c = mcmas_pkg::INDEX_W'($urandom_range(1, hi_c));
      end
      send_request(act, r, c, pick_value(), next_gap());
   endtask

   task automatic wait_drained();
      req_ch.valid = 1'b0;
      while (cells.pending.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_count(input logic [mcmas_pkg::CSR_IDX_W-1:0] idx,
                              input logic [mcmas_pkg::CFG_W-1:0] n);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = n;
      @(negedge clock);
      csr_we = 1'b0;
      cells.set_count(idx, n);
   endtask

   task automatic run_phase(input logic [mcmas_pkg::CFG_W-1:0] rows,
                            input logic [mcmas_pkg::CFG_W-1:0] cols,
                            input int items);
      wait_drained();
      write_count(mcmas_pkg::CSR_ROW_COUNT, rows);
      write_count(mcmas_pkg::CSR_COLUMN_COUNT, cols);
      repeat (items) send_random(1'b0);
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = mcmas_pkg::CSR_ROW_COUNT;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.action = mcmas_pkg::ACT_WRITE_A;
      req_ch.row = '0;
      req_ch.col = '0;
      req_ch.entry_value = '0;
      hold_request = 1'b0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      send_request(mcmas_pkg::ACT_WRITE_A, 1, 1, ENTRY_MAX, 0);
      send_request(mcmas_pkg::ACT_WRITE_A, 1, 16, ENTRY_MIN, 0);
      send_request(mcmas_pkg::ACT_WRITE_B, 1, 1, ENTRY_MIN, 1);
      send_request(mcmas_pkg::ACT_WRITE_B, 16, 1, ENTRY_MIN, 0);
      send_request(mcmas_pkg::ACT_WRITE_B, 16, 16, ENTRY_MAX, 2);
      send_request(mcmas_pkg::ACT_WRITE_A, 16, 16, ENTRY_MIN, 0);
      send_request(mcmas_pkg::ACT_WRITE_B, 1, 16, ENTRY_MAX, 0);
      send_request(mcmas_pkg::ACT_WRITE_A, 0, 5, ENTRY_MAX, 0);
      send_request(mcmas_pkg::ACT_WRITE_B, 17, 3, ENTRY_MAX, 0);
      send_request(mcmas_pkg::ACT_WRITE_A, 31, 31, ENTRY_MIN, 0);
      send_request(mcmas_pkg::ACT_PRODUCT, 1, 1, '0, 0);
      send_request(mcmas_pkg::ACT_SUM, 1, 1, '0, 3);
      send_request(mcmas_pkg::ACT_DIFF, 1, 1, ENTRY_MAX, 0);
      send_request(mcmas_pkg::ACT_PRODUCT, 16, 16, '0, 0);
      send_request(mcmas_pkg::ACT_DIFF, 16, 16, '0, 0);
      send_request(mcmas_pkg::ACT_SUM, 16, 16, '0, 0);
      send_request(mcmas_pkg::ACT_PRODUCT, 1, 16, '0, 0);
      send_request(ACT_SPARE_FIRST, 1, 1, ENTRY_MIN, 0);
      send_request(ACT_SPARE_LAST, 1, 1, ENTRY_MAX, 0);
      send_request(mcmas_pkg::ACT_PRODUCT, 0, 1, '0, 0);
      send_request(mcmas_pkg::ACT_SUM, 1, 0, '0, 0);
      send_request(mcmas_pkg::ACT_DIFF, 17, 1, '0, 0);
      send_request(mcmas_pkg::ACT_PRODUCT, 31, 31, '0, 0);
      send_request(mcmas_pkg::ACT_SUM, 2, 2, '0, 0);

      run_phase(DIM, DIM, 100);
      hold_request = 1'b1;
      repeat (30) send_random(1'b1);
      wait_drained();
      repeat (100) send_random(1'b0);
      run_phase(1, 1, 60);
      run_phase(0, 0, 30);
      run_phase(31, 31, 150);
      run_phase(17, 3, 100);
      run_phase(5, 12, 100);
      repeat (2) run_phase(mcmas_pkg::CFG_W'($urandom_range(1, DIM)),
                           mcmas_pkg::CFG_W'($urandom_range(1, DIM)), 120);
      run_phase(DIM, DIM, 100);
      wait_drained();

      if (cells.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
